FILE: hdl/ptrc_pkg.sv
package ptrc_pkg;

    localparam int KIND_W = 3;
    localparam int ETYPE_W = 2;
    localparam int ID_W = 64;
    localparam int SIDE_W = 2;
    localparam int PRICE_W = 32;
    localparam int QTY_W = 32;
    localparam int INSTR_W = 32;
    localparam int CODE_W = 4;
    localparam int EXP_W = 48;
    localparam int OUT_CNT_W = 32;
    localparam int NOTIONAL_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 184;
    localparam int NUM_REASONS = 8;

    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPROVED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [ETYPE_W-1:0] ETYPE_ADD = 2'd0;
    localparam logic [ETYPE_W-1:0] ETYPE_CANCEL = 2'd1;

    localparam logic [CODE_W-1:0] CODE_OK = 4'd0;
    localparam logic [CODE_W-1:0] CODE_BAD_QTY_ID = 4'd1;
    localparam logic [CODE_W-1:0] CODE_BAD_SIDE = 4'd2;
    localparam logic [CODE_W-1:0] CODE_BAD_PRICE = 4'd3;
    localparam logic [CODE_W-1:0] CODE_INSTR = 4'd4;
    localparam logic [CODE_W-1:0] CODE_BAND = 4'd5;
    localparam logic [CODE_W-1:0] CODE_MAX_QTY = 4'd6;
    localparam logic [CODE_W-1:0] CODE_NOTIONAL = 4'd7;
    localparam logic [CODE_W-1:0] CODE_EXPOSURE = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_INSTR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRICE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRICE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_QTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_NOTIONAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXPOSURE = 3'd5;

    typedef struct packed {
        logic [INSTR_W-1:0]    allowed_instrument;
        logic signed [PRICE_W-1:0] price_lo;
        logic signed [PRICE_W-1:0] price_hi;
        logic [QTY_W-1:0]      max_order_qty;
        logic [NOTIONAL_W-1:0] notional_cap;
        logic [EXP_W-1:0]      max_exposure;
    } cfg_t;

    // Classified item handed from front to back; the exposure test is left
    // to the back since it needs the live exposure.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ETYPE_W-1:0] event_type;
        logic [CODE_W-1:0]  pre_code;
        logic               need_exposure;
        logic [QTY_W-1:0]   qty;
    } cls_t;

endpackage

FILE: hdl/ptrc_front.sv
module ptrc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ptrc_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ptrc_pkg::S_TDATA_W-1:0]    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ptrc_pkg::cls_t                    out_cls
);
    import ptrc_pkg::*;

    logic [KIND_W-1:0]  kind;
    logic [ETYPE_W-1:0] etype;
    logic [ID_W-1:0]    id;
    logic [SIDE_W-1:0]  side;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [INSTR_W-1:0] instr;

    // stage 1: simple tests + notional product
    logic                 s1_valid_reg;
    logic [KIND_W-1:0]    s1_kind_reg;
    logic [ETYPE_W-1:0]   s1_etype_reg;
    logic [CODE_W-1:0]    s1_code_reg;
    logic                 s1_pend_reg;
    logic [QTY_W-1:0]     s1_qty_reg;
    logic [NOTIONAL_W-1:0] s1_prod_reg;
    logic [CODE_W-1:0]    code_next;
    logic                 pend_next;
    logic                 s1_adv;

    logic                 s2_valid_reg;
    cls_t                 s2_cls_reg;
    cls_t                 s2_next;
    logic                 s2_adv;

    assign kind  = in_data[2:0];
    assign etype = in_data[4:3];
    assign id    = in_data[68:5];
    assign side  = in_data[70:69];
    assign price = in_data[102:71];
    assign qty   = in_data[134:103];
    assign instr = in_data[166:135];

    always_comb begin
        code_next = CODE_OK;
        pend_next = 1'b0;
        if (etype == ETYPE_CANCEL) begin
            code_next = (id == '0) ? CODE_BAD_QTY_ID : CODE_OK;
        end else if (id == '0) begin
            code_next = CODE_BAD_QTY_ID;
        end else if (side > 2'd1) begin
            code_next = CODE_BAD_SIDE;
        end else if (price <= 0) begin
            code_next = CODE_BAD_PRICE;
        end else if (qty == '0) begin
            code_next = CODE_BAD_QTY_ID;
        end else if (cfg.allowed_instrument != '0 && instr != cfg.allowed_instrument) begin
            code_next = CODE_INSTR;
        end else if (price < cfg.price_lo || price > cfg.price_hi) begin
            code_next = CODE_BAND;
        end else if (qty > cfg.max_order_qty) begin
            code_next = CODE_MAX_QTY;
        end else begin
            pend_next = 1'b1;
        end
    end

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_comb begin
        s2_next.kind          = s1_kind_reg;
        s2_next.event_type    = s1_etype_reg;
        s2_next.qty           = s1_qty_reg;
        s2_next.pre_code      = s1_code_reg;
        s2_next.need_exposure = 1'b0;
        if (s1_pend_reg) begin
            if (s1_prod_reg > cfg.notional_cap) begin
                s2_next.pre_code = CODE_NOTIONAL;
            end else begin
                s2_next.need_exposure = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
        end
        if (s1_adv && in_valid) begin
            s1_kind_reg  <= kind;
            s1_etype_reg <= etype;
            s1_code_reg  <= code_next;
            s1_pend_reg  <= pend_next;
            s1_qty_reg   <= qty;
            s1_prod_reg  <= NOTIONAL_W'($unsigned(price[PRICE_W-2:0])) * NOTIONAL_W'(qty);
        end
        if (s2_adv && s1_valid_reg) s2_cls_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_cls   = s2_cls_reg;

endmodule

FILE: hdl/ptrc_fifo.sv
module ptrc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptrc_pkg::cls_t  in_cls,
    output logic            out_valid,
    input  logic            out_ready,
    output ptrc_pkg::cls_t  out_cls
);
    import ptrc_pkg::*;

    cls_t       mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cls   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
        if (push) mem_reg[wr_ptr_reg] <= in_cls;
    end

endmodule

FILE: hdl/ptrc_back.sv
module ptrc_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ptrc_pkg::EXP_W-1:0]      max_exposure,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ptrc_pkg::cls_t                  in_cls,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptrc_pkg::M_TDATA_W-1:0]  out_data
);
    import ptrc_pkg::*;

    logic [EXP_W-1:0]       exposure_reg;
    logic [COUNT_WIDTH-1:0] checked_reg;
    logic [COUNT_WIDTH-1:0] approved_reg;
    logic [COUNT_WIDTH-1:0] rejected_reg;
    logic [COUNT_WIDTH-1:0] reason_reg [NUM_REASONS];
    logic                   valid_reg;
    logic [M_TDATA_W-1:0]   data_reg;

    logic [EXP_W:0]         sum;
    logic [EXP_W-1:0]       exp_next;
    logic [COUNT_WIDTH-1:0] checked_next;
    logic [COUNT_WIDTH-1:0] approved_next;
    logic [COUNT_WIDTH-1:0] rejected_next;
    logic [COUNT_WIDTH-1:0] reason_next;
    logic [CODE_W-1:0]      code;
    logic [2:0]             ridx;
    logic                   fire;
    logic                   clr;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign sum      = {1'b0, exposure_reg} + (EXP_W+1)'(in_cls.qty);

    always_comb begin
        code          = in_cls.pre_code;
        exp_next      = exposure_reg;
        checked_next  = checked_reg;
        approved_next = approved_reg;
        rejected_next = rejected_reg;
        reason_next   = '0;
        clr           = 1'b0;
        if (in_cls.kind == KIND_CHECK && in_cls.need_exposure && sum > {1'b0, max_exposure})
            code = CODE_EXPOSURE;
        ridx = 3'(code - 4'd1);
        case (in_cls.kind)
            KIND_CHECK: begin
                checked_next = checked_reg + 1'b1;
                if (code == CODE_OK) begin
                    approved_next = approved_reg + 1'b1;
                end else begin
                    rejected_next = rejected_reg + 1'b1;
                    reason_next   = reason_reg[ridx] + 1'b1;
                end
            end
            KIND_APPROVED: begin
                code = CODE_OK;
                if (in_cls.event_type == ETYPE_ADD)
                    exp_next = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
            end
            KIND_FILL, KIND_RELEASE: begin
                code = CODE_OK;
                exp_next = (exposure_reg >= EXP_W'(in_cls.qty)) ?
                           exposure_reg - EXP_W'(in_cls.qty) : '0;
            end
            KIND_CLEAR: begin
                code          = CODE_OK;
                clr           = 1'b1;
                exp_next      = '0;
                checked_next  = '0;
                approved_next = '0;
                rejected_next = '0;
            end
            default: code = CODE_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            exposure_reg <= '0;
            checked_reg  <= '0;
            approved_reg <= '0;
            rejected_reg <= '0;
            for (int i = 0; i < NUM_REASONS; i++) reason_reg[i] <= '0;
        end else begin
            if (in_ready) valid_reg <= in_valid;
            if (fire) begin
                exposure_reg <= exp_next;
                checked_reg  <= checked_next;
                approved_reg <= approved_next;
                rejected_reg <= rejected_next;
                if (clr) begin
                    for (int i = 0; i < NUM_REASONS; i++) reason_reg[i] <= '0;
                end else if (in_cls.kind == KIND_CHECK && code != CODE_OK) begin
                    reason_reg[ridx] <= reason_next;
                end
            end
        end
        if (fire) begin
            data_reg <= M_TDATA_W'({OUT_CNT_W'(reason_next), OUT_CNT_W'(rejected_next),
                                    OUT_CNT_W'(approved_next), OUT_CNT_W'(checked_next),
                                    exp_next, code});
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/pre_trade_risk_checker.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_tvalid / s_tready       s_tdata: order event
// m_axis    out  m_tvalid / m_tready       m_tdata: check result
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One event per cycle sustained while m_tready stays high; an accepted event
// passes the two front stages, the queue and the back output register before
// m_tvalid rises. The exposure test and all counters sit in the back stage
// so each event sees state left by the previous one.
// aresetn clears exposure, counters and config to reset values.
// The front stalls only when the 4-entry queue is full.
module pre_trade_risk_checker #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // kind, event_type, id, side, price, qty, instrument
    input  logic [ptrc_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // risk_code, exposure_now, checked_count, approved_count,
    // rejected_count, reason_count
    output logic [ptrc_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ptrc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ptrc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ptrc_pkg::*;

    cfg_t cfg_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    cls_t f_cls, q_cls;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.allowed_instrument <= '0;
            cfg_reg.price_lo           <= 32'sd1;
            cfg_reg.price_hi           <= 32'sh7FFFFFFF;
            cfg_reg.max_order_qty      <= '1;
            cfg_reg.notional_cap       <= '1;
            cfg_reg.max_exposure       <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ALLOWED_INSTR: cfg_reg.allowed_instrument <= cfg_data[INSTR_W-1:0];
                REG_MIN_PRICE:     cfg_reg.price_lo <= cfg_data[PRICE_W-1:0];
                REG_MAX_PRICE:     cfg_reg.price_hi <= cfg_data[PRICE_W-1:0];
                REG_MAX_QTY:       cfg_reg.max_order_qty <= cfg_data[QTY_W-1:0];
                REG_MAX_NOTIONAL:  cfg_reg.notional_cap <= cfg_data;
                REG_MAX_EXPOSURE:  cfg_reg.max_exposure <= cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    ptrc_front u_front (
        .aclk, .aresetn, .cfg(cfg_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_cls(f_cls)
    );

    ptrc_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cls(f_cls),
        .out_valid(q_valid), .out_ready(q_ready), .out_cls(q_cls)
    );

    ptrc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .aclk, .aresetn, .max_exposure(cfg_reg.max_exposure),
        .in_valid(q_valid), .in_ready(q_ready), .in_cls(q_cls),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule
